@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the pixel blend ALU. All assertions
// are clocked on the rising edge of clock.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is low.
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ANY(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ hdl/argbpb_pkg.sv @@
// ----------------------------------------------------------------------------
// argbpb_pkg
// Widths, opcodes and stage payload types of the ARGB8888 pixel blend ALU.
// ----------------------------------------------------------------------------
package argbpb_pkg;

   localparam int unsigned CH_W      = 8;
   localparam int unsigned NUM_CH    = 4;
   localparam int unsigned COLOR_CH  = 3;
   localparam int unsigned PIX_W     = CH_W * NUM_CH;
   localparam int unsigned OP_W      = 3;
   localparam int unsigned ASUM_W    = CH_W + 1;
   localparam int unsigned PROD_W    = 2 * CH_W;
   localparam int unsigned NUM_W     = PROD_W + 1;
   localparam int unsigned DIV_STEPS = 4;

   // Channel order inside a pixel: alpha 3, red 2, green 1, blue 0.
   localparam int unsigned CH_ALPHA = 3;
   localparam int unsigned CH_RED   = 2;
   localparam int unsigned CH_GREEN = 1;
   localparam int unsigned CH_BLUE  = 0;

   localparam logic [OP_W-1:0] OP_INVERT = 3'd0;
   localparam logic [OP_W-1:0] OP_ADD    = 3'd1;
   localparam logic [OP_W-1:0] OP_MUL    = 3'd2;
   localparam logic [OP_W-1:0] OP_AVG    = 3'd3;
   localparam logic [OP_W-1:0] OP_WAVG   = 3'd4;

   localparam logic [CH_W-1:0] CH_MAX = 8'd255;

   typedef logic [CH_W-1:0] chan_type;

   // Payload after the multiply stage.
   typedef struct packed {
      logic [OP_W-1:0]                      op;
      logic [ASUM_W-1:0]                    asum;
      chan_type [NUM_CH-1:0]                res;
      logic [NUM_CH-1:0][PROD_W-1:0]        prod;
      logic [COLOR_CH-1:0][PROD_W-1:0]      lw;
      logic [COLOR_CH-1:0][PROD_W-1:0]      rw;
   } front_type;

   // Payload through the divider stages. The shift field holds the low
   // numerator bits still to be consumed and collects the quotient bits.
   typedef struct packed {
      logic [OP_W-1:0]                      op;
      logic [ASUM_W-1:0]                    dvs;
      chan_type [NUM_CH-1:0]                res;
      logic [COLOR_CH-1:0][ASUM_W-1:0]      rem;
      chan_type [COLOR_CH-1:0]              shf;
   } div_type;

endpackage

@@ hdl/argbpb_front.sv @@
// ----------------------------------------------------------------------------
// argbpb_front
// First stage: per-channel products, alpha sum and the simple operations.
// ----------------------------------------------------------------------------
module argbpb_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_vld,
   output logic                          in_rdy,
   input  logic [argbpb_pkg::OP_W-1:0]   opcode,
   input  logic [argbpb_pkg::PIX_W-1:0]  left_pixel,
   input  logic [argbpb_pkg::PIX_W-1:0]  right_pixel,
   output logic                          out_vld,
   input  logic                          out_rdy,
   output argbpb_pkg::front_type         out_data
);
   import argbpb_pkg::*;

   logic      vld_ff, vld_in;
   front_type data_ff, data_in;

   always_comb begin
      chan_type          la, ra, lc, rc;
      logic [ASUM_W-1:0] sum;
      la = left_pixel[CH_ALPHA*CH_W +: CH_W];
      ra = right_pixel[CH_ALPHA*CH_W +: CH_W];
      data_in      = '0;
      data_in.op   = opcode;
      data_in.asum = {1'b0, la} + {1'b0, ra};
      for (int i = 0; i < NUM_CH; i++) begin
         lc  = left_pixel[i*CH_W +: CH_W];
         rc  = right_pixel[i*CH_W +: CH_W];
         sum = {1'b0, lc} + {1'b0, rc};
         case (opcode)
            OP_INVERT: data_in.res[i] = CH_MAX - lc;
            OP_ADD:    data_in.res[i] = sum[CH_W] ? CH_MAX : sum[CH_W-1:0];
            OP_AVG:    data_in.res[i] = sum[ASUM_W-1:1];
            default:   data_in.res[i] = '0;
         endcase
         data_in.prod[i] = PROD_W'(lc) * PROD_W'(rc);
      end
      for (int i = 0; i < COLOR_CH; i++) begin
         data_in.lw[i] = PROD_W'(left_pixel[i*CH_W +: CH_W]) * PROD_W'(la);
         data_in.rw[i] = PROD_W'(right_pixel[i*CH_W +: CH_W]) * PROD_W'(ra);
      end
   end

   assign in_rdy = !vld_ff || out_rdy;

   always_comb begin
      vld_in = in_rdy ? in_vld : vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_vld && in_rdy) begin
         data_ff <= data_in;
      end
   end

   assign out_vld  = vld_ff;
   assign out_data = data_ff;

endmodule

@@ hdl/argbpb_mid.sv @@
// ----------------------------------------------------------------------------
// argbpb_mid
// Second stage: divide-by-255 of the products and the weighted numerators
// that seed the divider.
// ----------------------------------------------------------------------------
module argbpb_mid (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_vld,
   output logic                   in_rdy,
   input  argbpb_pkg::front_type  in_data,
   output logic                   out_vld,
   input  logic                   out_rdy,
   output argbpb_pkg::div_type    out_data
);
   import argbpb_pkg::*;

   logic    vld_ff, vld_in;
   div_type data_ff, data_in;

   // Exact floor(x / 255) for any product of two channels:
   // (x + (x >> 8) + 1) >> 8.
   function automatic chan_type div255(input logic [PROD_W-1:0] x);
      logic [NUM_W-1:0] t;
      t = NUM_W'(x) + NUM_W'(x >> CH_W) + NUM_W'(1);
      return t[PROD_W-1:CH_W];
   endfunction

   always_comb begin
      logic [NUM_W-1:0] num;
      data_in     = '0;
      data_in.op  = in_data.op;
      data_in.dvs = in_data.asum;
      for (int i = 0; i < NUM_CH; i++) begin
         if (in_data.op == OP_MUL) begin
            data_in.res[i] = div255(in_data.prod[i]);
         end else begin
            data_in.res[i] = in_data.res[i];
         end
      end
      // The numerator never reaches 256 times the alpha sum, so its top
      // bits already sit below the divisor.
      for (int i = 0; i < COLOR_CH; i++) begin
         num = NUM_W'(in_data.lw[i]) + NUM_W'(in_data.rw[i]);
         data_in.rem[i] = num[NUM_W-1 -: ASUM_W];
         data_in.shf[i] = num[CH_W-1:0];
      end
   end

   assign in_rdy = !vld_ff || out_rdy;

   always_comb begin
      vld_in = in_rdy ? in_vld : vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_vld && in_rdy) begin
         data_ff <= data_in;
      end
   end

   assign out_vld  = vld_ff;
   assign out_data = data_ff;

endmodule

@@ hdl/argbpb_div_stage.sv @@
// ----------------------------------------------------------------------------
// argbpb_div_stage
// One register stage of the restoring divider: four quotient bits for each
// colour channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module argbpb_div_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_vld,
   output logic                  in_rdy,
   input  argbpb_pkg::div_type   in_data,
   output logic                  out_vld,
   input  logic                  out_rdy,
   output argbpb_pkg::div_type   out_data
);
   import argbpb_pkg::*;

   logic    vld_ff, vld_in;
   div_type data_ff, data_in;

   always_comb begin
      logic [ASUM_W-1:0] rem_v;
      chan_type          shf_v;
      logic [ASUM_W:0]   trial;
      logic              qbit;
      data_in = in_data;
      for (int c = 0; c < COLOR_CH; c++) begin
         rem_v = in_data.rem[c];
         shf_v = in_data.shf[c];
         for (int s = 0; s < DIV_STEPS; s++) begin
            trial = {rem_v, shf_v[CH_W-1]};
            qbit  = (trial >= {1'b0, in_data.dvs});
            if (qbit) begin
               rem_v = ASUM_W'(trial - {1'b0, in_data.dvs});
            end else begin
               rem_v = trial[ASUM_W-1:0];
            end
            shf_v = {shf_v[CH_W-2:0], qbit};
         end
         data_in.rem[c] = rem_v;
         data_in.shf[c] = shf_v;
      end
   end

   assign in_rdy = !vld_ff || out_rdy;

   always_comb begin
      vld_in = in_rdy ? in_vld : vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_vld && in_rdy) begin
         data_ff <= data_in;
      end
   end

   assign out_vld  = vld_ff;
   assign out_data = data_ff;

   // A partial remainder always stays below a nonzero divisor.
   `ASSERT_CLK(a_rem_below_dvs,
      (vld_ff && (data_ff.dvs != '0)) |-> ((data_ff.rem[0] < data_ff.dvs) &&
      (data_ff.rem[1] < data_ff.dvs) && (data_ff.rem[2] < data_ff.dvs)),
      "divider remainder not below divisor")

endmodule

@@ hdl/argb_pixel_blend_alu_core.sv @@
// ----------------------------------------------------------------------------
// argb_pixel_blend_alu_core
// ARGB8888 pixel blend ALU: invert, saturating add, multiply, mean and
// alpha-weighted mean of two packed pixels, four pipeline stages.
//
//   Channel   Direction   Handshake            Payload
//   req_      in          req_valid/req_stall  opcode, left_pixel, right_pixel
//   rsp_      out         rsp_valid/rsp_stall  out_alpha/red/green/blue, flag
//
// One word is taken per cycle while req_stall is low; each word passes the
// front and mid stages and then the high and low stages of the two-stage
// restoring divider behind the multipliers, and leaves from the last stage.
// Synchronous reset empties all four stages; no payload is cleared.
// rsp_stall holds the last stage, and bubbles inside the pipe still close up.
// req_stall rises only when all four stages hold a word and the output waits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module argb_pixel_blend_alu_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [argbpb_pkg::OP_W-1:0]   req_opcode,
   input  logic [argbpb_pkg::PIX_W-1:0]  req_left_pixel,
   input  logic [argbpb_pkg::PIX_W-1:0]  req_right_pixel,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [argbpb_pkg::CH_W-1:0]   rsp_out_alpha,
   output logic [argbpb_pkg::CH_W-1:0]   rsp_out_red,
   output logic [argbpb_pkg::CH_W-1:0]   rsp_out_green,
   output logic [argbpb_pkg::CH_W-1:0]   rsp_out_blue,
   output logic                          rsp_zero_alpha_sum
);
   import argbpb_pkg::*;

   logic      s1_vld, s2_vld, s3_vld, s4_vld;
   logic      s1_rdy, s2_rdy, s3_rdy, s4_rdy;
   logic      req_rdy;
   front_type s1_data;
   div_type   s2_data, s3_data, s4_data;

   argbpb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_vld      (req_valid),
      .in_rdy      (req_rdy),
      .opcode      (req_opcode),
      .left_pixel  (req_left_pixel),
      .right_pixel (req_right_pixel),
      .out_vld     (s1_vld),
      .out_rdy     (s1_rdy),
      .out_data    (s1_data)
   );

   argbpb_mid u_mid (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (s1_vld),
      .in_rdy   (s1_rdy),
      .in_data  (s1_data),
      .out_vld  (s2_vld),
      .out_rdy  (s2_rdy),
      .out_data (s2_data)
   );

   argbpb_div_stage u_div_hi (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (s2_vld),
      .in_rdy   (s2_rdy),
      .in_data  (s2_data),
      .out_vld  (s3_vld),
      .out_rdy  (s3_rdy),
      .out_data (s3_data)
   );

   argbpb_div_stage u_div_lo (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (s3_vld),
      .in_rdy   (s3_rdy),
      .in_data  (s3_data),
      .out_vld  (s4_vld),
      .out_rdy  (s4_rdy),
      .out_data (s4_data)
   );

   assign req_stall = !req_rdy;
   assign s4_rdy    = !rsp_stall;
   assign rsp_valid = s4_vld;

   // Result select from the last stage register.
   always_comb begin
      rsp_out_alpha      = '0;
      rsp_out_red        = '0;
      rsp_out_green      = '0;
      rsp_out_blue       = '0;
      rsp_zero_alpha_sum = 1'b0;
      case (s4_data.op)
         OP_INVERT, OP_ADD, OP_MUL, OP_AVG: begin
            rsp_out_alpha = s4_data.res[CH_ALPHA];
            rsp_out_red   = s4_data.res[CH_RED];
            rsp_out_green = s4_data.res[CH_GREEN];
            rsp_out_blue  = s4_data.res[CH_BLUE];
         end
         OP_WAVG: begin
            if (s4_data.dvs == '0) begin
               rsp_zero_alpha_sum = 1'b1;
            end else begin
               rsp_out_alpha = s4_data.dvs[ASUM_W-1:1];
               rsp_out_red   = s4_data.shf[CH_RED];
               rsp_out_green = s4_data.shf[CH_GREEN];
               rsp_out_blue  = s4_data.shf[CH_BLUE];
            end
         end
         default: begin
            rsp_zero_alpha_sum = 1'b0;
         end
      endcase
   end

   `ASSERT_CLK(a_stall_when_full,
      req_stall |-> (s1_vld && s2_vld && s3_vld && s4_vld && rsp_stall),
      "input stalled with room in the pipe")
   `ASSERT_CLK(a_flag_clears_color,
      (rsp_valid && rsp_zero_alpha_sum) |-> ((s4_data.op == OP_WAVG) &&
      (rsp_out_alpha == '0) && (rsp_out_red == '0) && (rsp_out_green == '0) &&
      (rsp_out_blue == '0)),
      "zero alpha flag with nonzero channels")
   `ASSERT_ANY(a_empty_after_reset, reset |=> !rsp_valid, "result valid right after reset")

endmodule
